// ===== rtl/core/hsyk_pkg.sv =====
// package for the hartree screening y_k unit: formats, states, fixed-point helpers
// used by hsyk_mul and hartree_screening_yk_unit
`default_nettype none
package hsyk_pkg;
    localparam int MaxPoints = 1024;
    localparam int IdxW = $clog2(MaxPoints);
    localparam int CntW = IdxW + 1;
    localparam logic signed [47:0] S48Max = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] S48Min = 48'sh8000_0000_0000;
    localparam logic signed [47:0] QOne = 48'sd16777216;

    localparam logic [1:0] CfgPoints = 2'd0;
    localparam logic [1:0] CfgOrder = 2'd1;
    localparam logic [1:0] CfgStep = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DENS, ST_T, ST_RATIO, ST_POW, ST_OUTM, ST_OUTY, ST_WRITE,
        ST_READ, ST_READ2, ST_RESP,
        ST_IN_START, ST_IN_RD, ST_IN_RD2, ST_IN_TAILM, ST_IN_ACC,
        ST_IN_POW, ST_IN_MUL, ST_IN_ADD, ST_IN_DR, ST_IN_WR, ST_DONE
    } state_t;

    function automatic logic signed [47:0] add48(input logic signed [47:0] x,
                                                  input logic signed [47:0] y);
        logic signed [48:0] s;
        s = 49'(x) + 49'(y);
        if (s > 49'(S48Max)) return S48Max;
        if (s < 49'(S48Min)) return S48Min;
        return s[47:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/hsyk_mul.sv =====
// multicycle Q24.24 multiplier: 24x24 partial products, one per cycle
// depends on hsyk_pkg
`default_nettype none
module hsyk_mul
    import hsyk_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [47:0] op_x,
    input  wire logic signed [47:0] op_y,
    output logic                    done,
    output logic signed [47:0]      prod
);
    logic [2:0]  step_reg, step_next;
    logic        neg_reg, neg_next;
    logic [47:0] ux_reg, ux_next, uy_reg, uy_next;
    logic [95:0] acc_reg, acc_next;
    logic [23:0] a_sel, b_sel;
    logic [47:0] pp;
    logic [95:0] pp_sh;
    logic [47:0] mag;
    logic        ovf;

    // step 1..4 accumulates a_i*b_j, step 5 finishes
    always_comb begin
        a_sel = step_reg[1] ? ux_reg[47:24] : ux_reg[23:0];
        b_sel = step_reg[0] ? uy_reg[47:24] : uy_reg[23:0];
        pp = 48'(a_sel) * 48'(b_sel);
        pp_sh = 96'(pp) << (24 * (32'(step_reg[1]) + 32'(step_reg[0])));
    end

    always_comb begin
        step_next = step_reg;
        neg_next = neg_reg;
        ux_next = ux_reg;
        uy_next = uy_reg;
        acc_next = acc_reg;
        if (start) begin
            step_next = 3'd1;
            neg_next = op_x[47] ^ op_y[47];
            ux_next = op_x[47] ? 48'(-op_x) : op_x;
            uy_next = op_y[47] ? 48'(-op_y) : op_y;
            acc_next = '0;
        end else if (step_reg != 3'd0) begin
            // steps 1..4 use the low two bits of step as the partial-product selector
            acc_next = acc_reg + ((96'(pp) << 0) & '0) + pp_sh;
            step_next = (step_reg == 3'd4) ? 3'd5 : ((step_reg == 3'd5) ? 3'd0 : step_reg + 3'd1);
            if (step_reg == 3'd5) acc_next = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
        neg_reg <= neg_next;
        ux_reg <= ux_next;
        uy_reg <= uy_next;
        acc_reg <= acc_next;
    end

    always_comb begin
        ovf = |acc_reg[95:72];
        mag = acc_reg[71:24];
        if (neg_reg) begin
            if (ovf || mag >= 48'h8000_0000_0000) prod = S48Min;
            else prod = -$signed(mag);
        end else begin
            if (ovf || mag[47]) prod = S48Max;
            else prod = $signed(mag);
        end
        done = (step_reg == 3'd5);
    end
endmodule
`default_nettype wire

// ===== rtl/core/hartree_screening_yk_unit.sv =====
// hartree screening y_k unit: loads grid points, runs outward and inward recurrences
// depends on hsyk_pkg and hsyk_mul
// a multiply on the shared multiplier is a start followed by the partial-product steps;
// each load runs its multiplies in turn on it; the completing load
// adds an inward pass over every point of the grid;
// a read raises m_tvalid after ST_READ, ST_READ2 and ST_RESP. one item at a time, s_tready only in idle
// reset (synchronous, aresetn low) clears control state and counters; stores are undefined
`default_nettype none
module hartree_screening_yk_unit
    import hsyk_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [30:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // mode is tuser
    input  wire logic         s_tuser,
    // amp_a[31:0], amp_b[63:32], radius[94:64], inv_radius[125:95], read_index[135:126]
    input  wire logic [143:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // index_bad is tuser
    output logic              m_tuser,
    // value[47:0]
    output logic [47:0]       m_tdata
);
    logic [10:0] grid_points_reg;
    logic [3:0]  order_reg;
    logic [30:0] step_reg;

    state_t state_reg, state_next;
    logic [CntW-1:0] count_reg, count_next;
    logic signed [47:0] prev_dens_reg, prev_dens_next;
    logic [30:0] prev_rad_reg, prev_rad_next;
    logic signed [47:0] out_acc_reg, out_acc_next;
    logic signed [47:0] in_acc_reg, in_acc_next;
    logic signed [47:0] t_reg, t_next;
    logic signed [47:0] pw_reg, pw_next;
    logic [31:0] rat_reg, rat_next;
    logic [4:0]  pc_reg, pc_next;
    logic [IdxW-1:0] pos_reg, pos_next;
    logic signed [47:0] ra_reg, ra_next, rb_reg, rb_next;
    logic [31:0] in_a_reg, in_b_reg;
    logic [30:0] in_inv_reg, in_rad_reg;
    logic [IdxW-1:0] in_idx_reg;
    logic        started_reg, started_next;
    logic        ovalid_reg, ovalid_next;
    logic        obad_reg, obad_next;
    logic [47:0] oval_reg, oval_next;

    // stores
    logic signed [47:0] dens_mem [MaxPoints];
    logic [31:0]        rat_mem [MaxPoints];
    logic signed [47:0] res_mem [MaxPoints];
    logic [IdxW-1:0]    rd_addr;
    logic signed [47:0] dens_rd, res_rd;
    logic [31:0]        rat_rd;
    logic               dens_we, rat_we, res_we;
    logic [IdxW-1:0]    wr_addr;
    logic signed [47:0] dens_wd, res_wd;
    logic [31:0]        rat_wd;

    always_ff @(posedge aclk) begin
        if (dens_we) dens_mem[wr_addr] <= dens_wd;
        if (rat_we) rat_mem[wr_addr] <= rat_wd;
        if (res_we) res_mem[wr_addr] <= res_wd;
        dens_rd <= dens_mem[rd_addr];
        rat_rd <= rat_mem[rd_addr];
        res_rd <= res_mem[rd_addr];
    end

    // shared multiplier
    logic mul_start, mul_done;
    logic signed [47:0] mx, my, mp;
    hsyk_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .op_x(mx), .op_y(my), .done(mul_done), .prod(mp)
    );

    logic [CntW-1:0] n_eff;
    always_comb begin
        if (grid_points_reg < 11'd2) n_eff = CntW'(2);
        else if (grid_points_reg > 11'(MaxPoints)) n_eff = CntW'(MaxPoints);
        else n_eff = CntW'(grid_points_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_points_reg <= 11'd2;
            order_reg <= '0;
            step_reg <= 31'd16777216;
        end else if (cfg_we) begin
            case (cfg_index)
                CfgPoints: grid_points_reg <= cfg_wdata[10:0];
                CfgOrder:  order_reg <= cfg_wdata[3:0];
                CfgStep:   step_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic in_xfer;
    assign in_xfer = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_a_reg <= s_tdata[31:0];
            in_b_reg <= s_tdata[63:32];
            in_rad_reg <= s_tdata[94:64];
            in_inv_reg <= s_tdata[125:95];
            in_idx_reg <= s_tdata[135:126];
        end
    end

    // ratio saturated to 32 bits from product
    logic [31:0] rat_sat;
    assign rat_sat = (mp > 48'sh0000_FFFF_FFFF) ? 32'hFFFF_FFFF : mp[31:0];

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        prev_dens_next = prev_dens_reg;
        prev_rad_next = prev_rad_reg;
        out_acc_next = out_acc_reg;
        in_acc_next = in_acc_reg;
        t_next = t_reg;
        pw_next = pw_reg;
        rat_next = rat_reg;
        pc_next = pc_reg;
        pos_next = pos_reg;
        ra_next = ra_reg;
        rb_next = rb_reg;
        started_next = 1'b0;
        ovalid_next = ovalid_reg;
        obad_next = obad_reg;
        oval_next = oval_reg;
        if (ovalid_reg && m_tready) ovalid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser) state_next = ST_READ;
                    else begin
                        state_next = ST_DENS;
                        pos_next = (count_reg >= CntW'(MaxPoints)) ? IdxW'(MaxPoints - 1)
                                                                    : count_reg[IdxW-1:0];
                        started_next = 1'b1;
                    end
                end
            end
            ST_DENS: if (mul_done) begin t_next = mp; state_next = ST_T; started_next = 1'b1; end
            ST_T: if (mul_done) begin
                t_next = mp;
                if (pos_reg == '0) begin
                    rat_next = '0;
                    out_acc_next = '0;
                    ra_next = '0;
                    state_next = ST_WRITE;
                end else begin
                    state_next = ST_RATIO;
                    started_next = 1'b1;
                end
            end
            ST_RATIO: if (mul_done) begin
                rat_next = rat_sat;
                pw_next = QOne;
                pc_next = 5'(order_reg) + 5'd1;
                state_next = ST_POW;
                started_next = 1'b1;
            end
            ST_POW: if (mul_done) begin
                pw_next = mp;
                pc_next = pc_reg - 5'd1;
                if (pc_reg == 5'd1) begin
                    out_acc_next = add48(out_acc_reg, prev_dens_reg);
                    state_next = ST_OUTM;
                end
                started_next = 1'b1;
            end
            ST_OUTM: if (mul_done) begin
                out_acc_next = mp; state_next = ST_OUTY; started_next = 1'b1;
            end
            ST_OUTY: if (mul_done) begin ra_next = mp; state_next = ST_WRITE; end
            ST_WRITE: begin
                prev_dens_next = t_reg;
                prev_rad_next = in_rad_reg;
                count_next = CntW'(pos_reg) + CntW'(1);
                if (CntW'(pos_reg) + CntW'(1) >= n_eff) begin
                    pos_next = pos_reg;
                    state_next = ST_IN_START;
                end else state_next = ST_IDLE;
            end
            ST_IN_START: state_next = ST_IN_RD;
            ST_IN_RD: state_next = ST_IN_RD2;
            ST_IN_RD2: begin
                in_acc_next = dens_rd;
                state_next = ST_IN_TAILM;
                started_next = 1'b1;
            end
            ST_IN_TAILM: if (mul_done) begin rb_next = mp; state_next = ST_IN_WR; end
            ST_IN_WR: begin
                if (pos_reg == '0) state_next = ST_DONE;
                else begin
                    pw_next = QOne;
                    pc_next = 5'(order_reg);
                    rat_next = rat_rd;
                    pos_next = pos_reg - IdxW'(1);
                    state_next = ST_IN_ACC;
                end
            end
            ST_IN_ACC: begin
                // memory now reads pos (i-1); wait for registered data
                state_next = ST_IN_POW;
                started_next = (pc_reg != 5'd0);
            end
            ST_IN_POW: begin
                if (pc_reg == 5'd0) begin
                    state_next = ST_IN_MUL;
                    started_next = 1'b1;
                end else if (mul_done) begin
                    pw_next = mp;
                    pc_next = pc_reg - 5'd1;
                    started_next = (pc_reg != 5'd1);
                    if (pc_reg == 5'd1) begin
                        state_next = ST_IN_MUL;
                        started_next = 1'b1;
                    end
                end
            end
            ST_IN_MUL: if (mul_done) begin
                in_acc_next = add48(mp, dens_rd);
                state_next = ST_IN_ADD;
            end
            ST_IN_ADD: begin state_next = ST_IN_DR; started_next = 1'b1; end
            ST_IN_DR: if (mul_done) begin rb_next = mp; state_next = ST_IN_WR; end
            ST_DONE: begin
                count_next = '0;
                prev_dens_next = '0;
                prev_rad_next = '0;
                out_acc_next = '0;
                in_acc_next = '0;
                state_next = ST_IDLE;
            end
            ST_READ: state_next = ST_READ2;
            ST_READ2: state_next = ST_RESP;
            ST_RESP: begin
                if (!ovalid_reg || m_tready) begin
                    ovalid_next = 1'b1;
                    if (CntW'(in_idx_reg) >= n_eff) begin
                        obad_next = 1'b1;
                        oval_next = '0;
                    end else begin
                        obad_next = 1'b0;
                        oval_next = res_rd;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // operand, memory and write control
    always_comb begin
        mul_start = started_reg;
        mx = '0;
        my = '0;
        rd_addr = pos_reg;
        dens_we = 1'b0;
        rat_we = 1'b0;
        res_we = 1'b0;
        wr_addr = pos_reg;
        dens_wd = t_reg;
        rat_wd = rat_reg;
        res_wd = ra_reg;
        case (state_reg)
            ST_DENS: begin mx = 48'(signed'(in_a_reg)); my = 48'(signed'(in_b_reg)); end
            ST_T: begin mx = t_reg; my = 48'({17'd0, in_inv_reg}); end
            ST_RATIO: begin mx = 48'({17'd0, prev_rad_reg}); my = 48'({17'd0, in_inv_reg}); end
            ST_POW: begin mx = pw_reg; my = 48'({16'd0, rat_reg}); end
            // outward accumulator times the ratio power, then times dr
            ST_OUTM: begin mx = out_acc_reg; my = pw_reg; end
            ST_OUTY: begin mx = out_acc_reg; my = 48'({17'd0, step_reg}); end
            ST_WRITE: begin dens_we = 1'b1; rat_we = 1'b1; res_we = 1'b1; end
            ST_IN_RD2: begin mx = dens_rd; my = 48'({17'd0, step_reg}); end
            ST_IN_TAILM: begin mx = in_acc_reg; my = 48'({17'd0, step_reg}); end
            ST_IN_WR: begin
                res_we = 1'b1;
                res_wd = add48(res_rd, rb_reg);
                rd_addr = pos_reg - IdxW'(1);
            end
            ST_IN_ACC: begin mx = QOne; my = 48'({16'd0, rat_reg}); end
            ST_IN_POW: begin
                if (pc_reg == 5'd0 || (mul_done && pc_reg == 5'd1)) begin
                    mx = in_acc_reg; my = (pc_reg == 5'd0) ? pw_reg : mp;
                end else begin
                    mx = mul_done ? mp : pw_reg; my = 48'({16'd0, rat_reg});
                end
            end
            ST_IN_MUL: begin mx = in_acc_reg; my = pw_reg; end
            ST_IN_ADD: begin mx = in_acc_reg; my = 48'({17'd0, step_reg}); end
            ST_IN_DR: begin mx = in_acc_reg; my = 48'({17'd0, step_reg}); end
            ST_READ, ST_READ2, ST_RESP: rd_addr = in_idx_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            prev_dens_reg <= '0;
            prev_rad_reg <= '0;
            out_acc_reg <= '0;
            in_acc_reg <= '0;
            started_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            prev_dens_reg <= prev_dens_next;
            prev_rad_reg <= prev_rad_next;
            out_acc_reg <= out_acc_next;
            in_acc_reg <= in_acc_next;
            started_reg <= started_next;
            ovalid_reg <= ovalid_next;
        end
        t_reg <= t_next;
        pw_reg <= pw_next;
        rat_reg <= rat_next;
        pc_reg <= pc_next;
        pos_reg <= pos_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
        obad_reg <= obad_next;
        oval_reg <= oval_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser = obad_reg;
    assign m_tdata = oval_reg;
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for hartree_screening_yk_unit: random bursts of grid loads and reads
// checked against an in-bench fixed-point predictor of the y_k recurrences
// depends on hsyk_pkg and the rtl of hartree_screening_yk_unit
`default_nettype none
module tb_top
    import hsyk_pkg::*;
();

    localparam longint CycleLimit = 3000000;

    typedef struct {
        logic        mode;
        logic [31:0] amp_a;
        logic [31:0] amp_b;
        logic [30:0] radius;
        logic [30:0] inv_radius;
        logic [9:0]  read_index;
    } grid_item_t;

    typedef struct {
        logic [47:0] value;
        logic        index_bad;
    } yk_read_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [30:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic         s_tuser;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic         m_tuser;
    logic [47:0]  m_tdata;

    hartree_screening_yk_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
    );

    // stimulus waiting for the driver, and expected read responses
    grid_item_t pending_items[$];
    yk_read_t   expected_reads[$];
    logic       hold_input;
    longint     cyc;
    int         mismatches;

    // predictor copy of the registers and the recurrence state
    logic [10:0]   pr_grid;
    logic [3:0]    pr_order;
    logic [30:0]   pr_step;
    int            pr_count;
    longint        pr_prev_dens;
    longint        pr_prev_rad;
    longint        pr_out_acc;
    longint        pr_in_acc;
    longint        pr_dens[MaxPoints];
    longint        pr_ratio[MaxPoints];
    longint        pr_yk[MaxPoints];

    // stimulus-side view: how many points loaded so far and how far results are written
    int gen_count;
    int gen_written;
    int gen_points;

    // ---------------------------------------------------------------- clock, reset
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ---------------------------------------------------------------- fixed-point predictor
    function automatic longint clamp48(longint v);
        if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
        if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
        return v;
    endfunction

    function automatic longint sum48(longint x, longint y);
        return clamp48(clamp48(x) + clamp48(y));
    endfunction

    // exact product, 24 fraction bits dropped toward zero, saturated to 48 bits
    function automatic longint fx_mul(longint x, longint y);
        logic          neg;
        logic [63:0]   ux;
        logic [63:0]   uy;
        logic [127:0]  prod;
        neg  = (x < 0) != (y < 0);
        ux   = (x < 0) ? -x : x;
        uy   = (y < 0) ? -y : y;
        prod = ({64'd0, ux} * {64'd0, uy}) >> 24;
        if (neg) begin
            if (prod >= (128'd1 << 47)) return -64'sh8000_0000_0000;
            return -longint'(prod[47:0]);
        end
        if (prod > 128'h7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
        return longint'(prod[47:0]);
    endfunction

    function automatic longint fx_pow(longint base, int n);
        longint p;
        p = 64'sd16777216;
        for (int i = 0; i < n; i++) p = fx_mul(p, base);
        return p;
    endfunction

    function automatic int grid_in_use(logic [10:0] g);
        if (g < 2) return 2;
        if (g > MaxPoints) return MaxPoints;
        return int'(g);
    endfunction

    // walk inward from the outermost point, accumulating into the stored y_k
    function automatic void run_inward(int n);
        longint dr;
        dr = longint'(pr_step);
        pr_in_acc = pr_dens[n-1];
        pr_yk[n-1] = sum48(pr_yk[n-1], fx_mul(pr_in_acc, dr));
        for (int i = n - 1; i >= 1; i--) begin
            pr_in_acc = sum48(fx_mul(pr_in_acc, fx_pow(pr_ratio[i], int'(pr_order))),
                              pr_dens[i-1]);
            pr_yk[i-1] = sum48(pr_yk[i-1], fx_mul(pr_in_acc, dr));
        end
    endfunction

    function automatic void predict_item(grid_item_t it);
        int        pos;
        longint    dens;
        longint    t;
        longint    r;
        longint    rat;
        yk_read_t  rd;
        if (it.mode) begin
            if (it.read_index >= grid_in_use(pr_grid)) begin
                rd.value = '0;
                rd.index_bad = 1'b1;
            end else begin
                rd.value = pr_yk[it.read_index][47:0];
                rd.index_bad = 1'b0;
            end
            expected_reads.push_back(rd);
            return;
        end
        pos = (pr_count >= MaxPoints) ? MaxPoints - 1 : pr_count;
        dens = fx_mul(longint'($signed(it.amp_a)), longint'($signed(it.amp_b)));
        t = fx_mul(dens, longint'(it.inv_radius));
        pr_dens[pos] = t;
        if (pos == 0) begin
            pr_ratio[0] = 0;
            pr_out_acc = 0;
            pr_yk[0] = 0;
        end else begin
            r = fx_mul(pr_prev_rad, longint'(it.inv_radius));
            rat = (r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : r;
            pr_ratio[pos] = rat;
            pr_out_acc = fx_mul(sum48(pr_out_acc, pr_prev_dens),
                                fx_pow(rat, int'(pr_order) + 1));
            pr_yk[pos] = fx_mul(pr_out_acc, longint'(pr_step));
        end
        pr_prev_dens = t;
        pr_prev_rad = longint'(it.radius);
        pr_count = pos + 1;
        // last point of the grid: tail term and inward pass, then a fresh function
        if (pr_count >= grid_in_use(pr_grid)) begin
            run_inward(pr_count);
            pr_count = 0;
            pr_prev_dens = 0;
            pr_prev_rad = 0;
            pr_out_acc = 0;
            pr_in_acc = 0;
        end
    endfunction

    // ---------------------------------------------------------------- driver
    int burst_left;
    int gap_left;
    grid_item_t on_bus;

    always @(posedge aclk) begin
        grid_item_t nxt;
        logic       nxt_valid;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tuser    <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_tvalid && s_tready) predict_item(on_bus);
            if (!s_tvalid || s_tready) begin
                nxt_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end else if (pending_items.size() > 0 && !hold_input) begin
                    nxt = pending_items.pop_front();
                    on_bus = nxt;
                    nxt_valid = 1'b1;
                    s_tuser <= nxt.mode;
                    s_tdata <= {8'd0, nxt.read_index, nxt.inv_radius, nxt.radius,
                                nxt.amp_b, nxt.amp_a};
                    if (burst_left <= 1) begin
                        // new burst; a third of bursts follow without any gap
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
                s_tvalid <= nxt_valid;
            end
        end
    end

    // ---------------------------------------------------------------- receiver and checker
    always @(posedge aclk) begin
        yk_read_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            // stall pattern follows bits 9:8 of the cycle count: open, coin flip, periodic, mostly stalled
            case (cyc[9:8])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= $urandom_range(0, 1);
                2'd2: m_tready <= (cyc % 7) != 0;
                default: m_tready <= ($urandom_range(0, 5) == 0);
            endcase
            if (m_tvalid && m_tready) begin
                if (expected_reads.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: value %h index_bad %b", m_tdata, m_tuser);
                end else begin
                    want = expected_reads.pop_front();
                    if (want.value !== m_tdata || want.index_bad !== m_tuser) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("read mismatch: expected value %h bad %b, got %h bad %b",
                                     want.value, want.index_bad, m_tdata, m_tuser);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > CycleLimit) begin
            $display("** hartree_screening_yk_unit: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic queue_load(logic [31:0] a, logic [31:0] b, logic [30:0] r, logic [30:0] inv);
        grid_item_t it;
        int         pos;
        it.mode = 1'b0;
        it.amp_a = a;
        it.amp_b = b;
        it.radius = r;
        it.inv_radius = inv;
        it.read_index = 10'($urandom);
        pending_items.push_back(it);
        pos = (gen_count >= MaxPoints) ? MaxPoints - 1 : gen_count;
        if (pos + 1 > gen_written) gen_written = pos + 1;
        gen_count = pos + 1;
        if (gen_count >= gen_points) gen_count = 0;
    endtask

    // well-formed point: radius grows with the index, inverse radius matches it
    task automatic queue_grid_point(int h);
        logic [30:0] r;
        r = 31'((gen_count + 1) * h);
        queue_load(32'($urandom_range(0, 1 << 27) - (1 << 26)),
                   32'($urandom_range(0, 1 << 27) - (1 << 26)),
                   r, 31'((64'd1 << 48) / r));
    endtask

    // reads of result entries never written are steered elsewhere
    task automatic queue_read(int idx);
        grid_item_t it;
        if (idx < gen_points && idx >= gen_written) begin
            if (gen_written > 0) idx = $urandom_range(0, gen_written - 1);
            else if (gen_points < MaxPoints) idx = $urandom_range(gen_points, MaxPoints - 1);
            else return;
        end
        it.mode = 1'b1;
        it.amp_a = $urandom;
        it.amp_b = $urandom;
        it.radius = 31'($urandom);
        it.inv_radius = 31'($urandom);
        it.read_index = 10'(idx);
        pending_items.push_back(it);
    endtask

    // let the queue drain and every read answer, then pause the sender
    // and wait until the block is back in idle
    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_items.size() > 0 || s_tvalid || expected_reads.size() > 0);
        hold_input = 1'b1;
        repeat (3) @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic set_registers(logic [10:0] g, logic [3:0] k, logic [30:0] dr);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CfgPoints;
        cfg_wdata <= 31'(g);
        @(posedge aclk);
        cfg_index <= CfgOrder;
        cfg_wdata <= 31'(k);
        @(posedge aclk);
        cfg_index <= CfgStep;
        cfg_wdata <= dr;
        @(posedge aclk);
        cfg_we <= 1'b0;
        pr_grid = g;
        pr_order = k;
        pr_step = dr;
        gen_points = grid_in_use(g);
    endtask

    task automatic run_phase(logic [10:0] g, logic [3:0] k, logic [30:0] dr, int n_items);
        int h;
        wait_idle();
        set_registers(g, k, dr);
        h = $urandom_range(1 << 18, 1 << 20);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 5) == 0) queue_read($urandom_range(0, MaxPoints - 1));
                else queue_read($urandom_range(0, gen_points + 2));
            end else if ($urandom_range(0, 99) < 85) begin
                queue_grid_point(h);
            end else begin
                // noise: any bit pattern in every field
                queue_load($urandom, $urandom, 31'($urandom), 31'($urandom));
            end
        end
        hold_input = 1'b0;
    endtask

    initial begin
        cyc = 0;
        mismatches = 0;
        hold_input = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CfgPoints;
        cfg_wdata = '0;
        m_tready = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        pr_grid = 11'd2;
        pr_order = 4'd0;
        pr_step = 31'd16777216;
        pr_count = 0;
        pr_prev_dens = 0;
        pr_prev_rad = 0;
        pr_out_acc = 0;
        pr_in_acc = 0;
        gen_count = 0;
        gen_written = 0;
        gen_points = 2;

        // directed part at reset settings
        queue_read(5);
        queue_read(1023);
        queue_load(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        queue_load(32'h7FFF_FFFF, 32'h8000_0000, 31'd0, 31'd0);
        queue_read(0);
        queue_read(1);
        queue_read(2);
        queue_load(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF);
        queue_load(32'h0000_0000, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'd1);
        queue_read(0);
        queue_read(1);
        queue_grid_point(1 << 22);
        queue_grid_point(1 << 22);
        queue_read(0);
        queue_read(1);
        queue_read(512);

        // register writes while idle, covering the clamps and the extremes
        run_phase(11'd0, 4'd0, 31'd16777216, 60);
        run_phase(11'd1, 4'd15, 31'd0, 60);
        run_phase(11'd3, 4'd1, 31'h7FFF_FFFF, 70);
        run_phase(11'd5, 4'd2, 31'($urandom_range(1 << 20, 1 << 26)), 70);
        run_phase(11'd40, 4'd15, 31'($urandom_range(1 << 20, 1 << 26)), 80);
        run_phase(11'd8, 4'd7, 31'($urandom), 70);
        run_phase(11'd16, 4'd3, 31'($urandom_range(1 << 20, 1 << 26)), 70);
        run_phase(11'd2047, 4'd2, 31'($urandom_range(1 << 18, 1 << 24)), 70);
        run_phase(11'd1024, 4'd0, 31'($urandom_range(1 << 18, 1 << 24)), 60);
        run_phase(11'($urandom_range(2, 12)), 4'($urandom_range(0, 15)),
                  31'($urandom_range(1 << 20, 1 << 26)), 70);
        run_phase(11'd4, 4'd8, 31'd1, 60);

        wait_idle();
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && expected_reads.size() == 0) begin
            $display("** hartree_screening_yk_unit: PASSED **");
        end else begin
            $display("** hartree_screening_yk_unit: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/hsyk_pkg.sv
rtl/core/hsyk_mul.sv
rtl/core/hartree_screening_yk_unit.sv
tb/sv/tb_top.sv
